// ===== hdl/tdq_pkg.sv =====
`default_nettype none
package tdq_pkg;

    localparam int DEPTH       = 16;
    localparam int HANDLE_BITS = 16;
    localparam int DL_W        = 64;
    localparam int FREQ_W      = 32;
    localparam int IDX_W       = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W       = $clog2(DEPTH + 1);
    localparam int CHILD_W     = IDX_W + 2;
    localparam int PROD_W      = DL_W + FREQ_W;
    localparam int REM_W       = 30;
    localparam int LIMB_W      = 32;
    localparam int MQ_W        = 64;
    localparam int CUR_W       = REM_W + LIMB_W;
    localparam int DIFF_W      = 34;

    localparam logic [REM_W-1:0]  NS_PER_S   = REM_W'(1000000000);
    localparam logic [FREQ_W-1:0] FREQ_RESET = FREQ_W'(19200000);

    // floor(2^61 / 1e9): limb quotient estimate is (cur >> 30) * RECIP_NS >> 31
    localparam logic [LIMB_W-1:0] RECIP_NS = 32'd2305843009;
    localparam logic [DIFF_W-1:0] NS_X1    = 34'd1000000000;
    localparam logic [DIFF_W-1:0] NS_X2    = 34'd2000000000;
    localparam logic [DIFF_W-1:0] NS_X3    = 34'd3000000000;
    localparam logic [DIFF_W-1:0] NS_X4    = 34'd4000000000;

    localparam logic OP_ADD  = 1'b0;
    localparam logic OP_FIRE = 1'b1;

    typedef struct packed {
        logic [DL_W-1:0]        dl;
        logic [HANDLE_BITS-1:0] h;
    } t_entry;

    // one bit per datapath step, driven by the controller
    typedef struct packed {
        logic load;
        logic mul0;
        logic mul1;
        logic sum;
        logic div;
        logic add;
        logic cmp;
        logic up_rd;
        logic up_cmp;
        logic fire_rd;
        logic fire_ld;
        logic dn_rd;
        logic dn_cmp;
        logic fin_rd;
        logic fin;
    } t_cmd;

    typedef struct packed {
        logic is_fire;
        logic full;
        logic empty;
        logic div_last;
        logic up_top;
        logic up_move;
        logic new_empty;
        logic dn_move;
    } t_stat;

    // earlier deadline leaves first, ties go to the smaller handle
    function automatic logic earlier(input t_entry a, input t_entry b);
        logic res;
        if (a.dl != b.dl) begin
            res = (a.dl < b.dl);
        end else begin
            res = (a.h < b.h);
        end
        return res;
    endfunction

endpackage
`default_nettype wire

// ===== hdl/tdq_ctrl.sv =====
`default_nettype none
module tdq_ctrl
    import tdq_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_start,
    input  wire t_stat i_stat,
    output t_cmd       o_cmd,
    output logic       o_busy,
    output logic       o_done
);

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_MUL0    = 4'd1;
    localparam logic [3:0] S_MUL1    = 4'd2;
    localparam logic [3:0] S_SUM     = 4'd3;
    localparam logic [3:0] S_DIV     = 4'd4;
    localparam logic [3:0] S_ADD     = 4'd5;
    localparam logic [3:0] S_CMP     = 4'd6;
    localparam logic [3:0] S_UP_RD   = 4'd7;
    localparam logic [3:0] S_UP_CMP  = 4'd8;
    localparam logic [3:0] S_FIRE_RD = 4'd9;
    localparam logic [3:0] S_FIRE_LD = 4'd10;
    localparam logic [3:0] S_DN_RD   = 4'd11;
    localparam logic [3:0] S_DN_CMP  = 4'd12;
    localparam logic [3:0] S_FIN_RD  = 4'd13;
    localparam logic [3:0] S_FIN     = 4'd14;
    localparam logic [3:0] S_DONE    = 4'd15;

    logic [3:0] r_state;
    logic [3:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    if (i_stat.is_fire) begin
                        n_state = i_stat.empty ? S_DONE : S_FIRE_RD;
                    end else begin
                        n_state = i_stat.full ? S_DONE : S_MUL0;
                    end
                end
            end
            S_MUL0: begin
                o_cmd.mul0 = 1'b1;
                n_state    = S_MUL1;
            end
            S_MUL1: begin
                o_cmd.mul1 = 1'b1;
                n_state    = S_SUM;
            end
            S_SUM: begin
                o_cmd.sum = 1'b1;
                n_state   = S_DIV;
            end
            S_DIV: begin
                o_cmd.div = 1'b1;
                if (i_stat.div_last) begin
                    n_state = S_ADD;
                end
            end
            S_ADD: begin
                o_cmd.add = 1'b1;
                n_state   = S_CMP;
            end
            S_CMP: begin
                o_cmd.cmp = 1'b1;
                n_state   = S_UP_RD;
            end
            S_UP_RD: begin
                o_cmd.up_rd = 1'b1;
                n_state     = i_stat.up_top ? S_DONE : S_UP_CMP;
            end
            S_UP_CMP: begin
                o_cmd.up_cmp = 1'b1;
                n_state      = i_stat.up_move ? S_UP_RD : S_DONE;
            end
            S_FIRE_RD: begin
                o_cmd.fire_rd = 1'b1;
                n_state       = S_FIRE_LD;
            end
            S_FIRE_LD: begin
                o_cmd.fire_ld = 1'b1;
                n_state       = i_stat.new_empty ? S_DONE : S_DN_RD;
            end
            S_DN_RD: begin
                o_cmd.dn_rd = 1'b1;
                n_state     = S_DN_CMP;
            end
            S_DN_CMP: begin
                o_cmd.dn_cmp = 1'b1;
                n_state      = i_stat.dn_move ? S_DN_RD : S_FIN_RD;
            end
            S_FIN_RD: begin
                o_cmd.fin_rd = 1'b1;
                n_state      = S_FIN;
            end
            S_FIN: begin
                o_cmd.fin = 1'b1;
                n_state   = S_DONE;
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_done = (r_state == S_DONE);

endmodule
`default_nettype wire

// ===== hdl/tdq_dpath.sv =====
`default_nettype none
module tdq_dpath
    import tdq_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire t_cmd                   i_cmd,
    output t_stat                       o_stat,
    input  wire logic                   i_cfg_we,
    input  wire logic [FREQ_W-1:0]      i_cfg_data,
    input  wire logic                   i_opcode,
    input  wire logic [DL_W-1:0]        i_now_count,
    input  wire logic [DL_W-1:0]        i_delay_ns,
    input  wire logic [HANDLE_BITS-1:0] i_handle,
    output logic                        o_accepted,
    output logic                        o_expired_valid,
    output logic [HANDLE_BITS-1:0]      o_expired_handle,
    output logic                        o_compare_write,
    output logic [DL_W-1:0]             o_compare_value,
    output logic                        o_irq_unmasked,
    output logic [CNT_W-1:0]            o_entry_count
);

    localparam logic [1:0] PH_EST    = 2'd0;
    localparam logic [1:0] PH_SUB    = 2'd1;
    localparam logic [1:0] PH_FIX    = 2'd2;
    localparam logic [1:0] LAST_LIMB = 2'd2;

    // control state
    logic [FREQ_W-1:0] r_freq;
    logic [CNT_W-1:0]  r_count;
    logic              r_irq;

    // item and arithmetic
    logic [DL_W-1:0]        r_now;
    logic [DL_W-1:0]        r_delay;
    logic [HANDLE_BITS-1:0] r_handle;
    logic [DL_W-1:0]        r_p0;
    logic [DL_W-1:0]        r_p1;
    logic [PROD_W-1:0]      r_prod;
    logic [REM_W-1:0]       r_rem;
    logic [DL_W-1:0]        r_quot;
    logic [1:0]             r_phase;
    logic [1:0]             r_limb;
    logic [MQ_W-1:0]        r_mq;
    logic [LIMB_W-1:0]      r_qe;
    logic [DIFF_W-1:0]      r_diff;

    // heap walk
    t_entry             r_x;
    logic [IDX_W-1:0]   r_hole;
    logic [IDX_W-1:0]   r_par;
    logic [CHILD_W-1:0] r_l;
    logic [CHILD_W-1:0] r_r;

    // result
    logic                   r_accepted;
    logic                   r_exp_valid;
    logic [HANDLE_BITS-1:0] r_exp_handle;
    logic                   r_cmp_write;
    logic [DL_W-1:0]        r_cmp_value;

    // heap store
    t_entry           mem [DEPTH];
    t_entry           r_qa;
    t_entry           r_qb;
    logic [IDX_W-1:0] rd_a;
    logic [IDX_W-1:0] rd_b;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    t_entry           wr_data;

    logic [LIMB_W-1:0]  limb;
    logic [CUR_W-1:0]   div_cur;
    logic [LIMB_W-1:0]  est_in;
    logic [LIMB_W-1:0]  qe;
    logic [CUR_W-1:0]   qe_back;
    logic [CUR_W-1:0]   div_diff;
    logic [2:0]         fix_k;
    logic [DIFF_W-1:0]  fix_sub;
    logic [DIFF_W-1:0]  fix_rem;
    logic [IDX_W-1:0]   parent;
    logic [CHILD_W-1:0] l_idx;
    logic [CHILD_W-1:0] cnt_ext;
    logic               l_ok;
    logic               r_ok;
    logic               pick_r;
    t_entry             child;
    logic [IDX_W-1:0]   child_idx;
    logic               up_move;
    logic               dn_move;
    logic [CNT_W-1:0]   cnt_dec;

    assign limb      = r_prod[PROD_W-1 -: LIMB_W];
    assign div_cur   = {r_rem, limb};
    assign est_in    = div_cur[CUR_W-1 -: LIMB_W];
    assign qe        = r_mq[MQ_W-2 -: LIMB_W];
    assign qe_back   = qe * NS_PER_S;
    assign div_diff  = div_cur - qe_back;
    assign fix_rem   = r_diff - fix_sub;
    assign parent    = (r_hole - IDX_W'(1)) >> 1;
    assign l_idx     = {1'b0, r_hole, 1'b1};
    assign cnt_ext   = CHILD_W'(r_count);
    assign cnt_dec   = r_count - CNT_W'(1);
    assign l_ok      = (r_l < cnt_ext);
    assign r_ok      = (r_r < cnt_ext);
    assign pick_r    = r_ok && earlier(r_qb, r_qa);
    assign child     = pick_r ? r_qb : r_qa;
    assign child_idx = pick_r ? r_r[IDX_W-1:0] : r_l[IDX_W-1:0];
    assign up_move   = earlier(r_x, r_qa);
    assign dn_move   = l_ok && earlier(child, r_x);

    // the estimate falls short of the limb quotient by at most four
    always_comb begin
        if (r_diff >= NS_X4) begin
            fix_k   = 3'd4;
            fix_sub = NS_X4;
        end else if (r_diff >= NS_X3) begin
            fix_k   = 3'd3;
            fix_sub = NS_X3;
        end else if (r_diff >= NS_X2) begin
            fix_k   = 3'd2;
            fix_sub = NS_X2;
        end else if (r_diff >= NS_X1) begin
            fix_k   = 3'd1;
            fix_sub = NS_X1;
        end else begin
            fix_k   = 3'd0;
            fix_sub = '0;
        end
    end

    always_comb begin
        rd_a    = '0;
        rd_b    = '0;
        wr_en   = 1'b0;
        wr_addr = r_hole;
        wr_data = r_x;
        if (i_cmd.up_rd) begin
            rd_a  = parent;
            wr_en = (r_hole == '0);
        end
        if (i_cmd.up_cmp) begin
            wr_en   = 1'b1;
            wr_data = up_move ? r_qa : r_x;
        end
        if (i_cmd.fire_rd) begin
            rd_b = cnt_dec[IDX_W-1:0];
        end
        if (i_cmd.dn_rd) begin
            rd_a = l_idx[IDX_W-1:0];
            rd_b = CHILD_W'(l_idx + CHILD_W'(1)) >= CHILD_W'(DEPTH) ? '0 :
                   IDX_W'(l_idx + CHILD_W'(1));
        end
        if (i_cmd.dn_cmp) begin
            wr_en   = 1'b1;
            wr_data = dn_move ? child : r_x;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        r_qa <= mem[rd_a];
        r_qb <= mem[rd_b];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_freq  <= FREQ_RESET;
            r_count <= '0;
            r_irq   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_freq <= i_cfg_data;
            end
            if ((i_cmd.up_rd && r_hole == '0) || (i_cmd.up_cmp && !up_move)) begin
                r_count <= r_count + CNT_W'(1);
                r_irq   <= 1'b1;
            end
            if (i_cmd.fire_ld) begin
                r_count <= cnt_dec;
                if (cnt_dec == '0) begin
                    r_irq <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_now        <= i_now_count;
            r_delay      <= i_delay_ns;
            r_handle     <= i_handle;
            r_accepted   <= 1'b0;
            r_exp_valid  <= 1'b0;
            r_exp_handle <= '0;
            r_cmp_write  <= 1'b0;
            r_cmp_value  <= '0;
        end
        if (i_cmd.mul0) begin
            r_p0 <= r_delay[FREQ_W-1:0] * r_freq;
        end
        if (i_cmd.mul1) begin
            r_p1 <= r_delay[DL_W-1:FREQ_W] * r_freq;
        end
        if (i_cmd.sum) begin
            r_prod  <= {{FREQ_W{1'b0}}, r_p0} + {r_p1, {FREQ_W{1'b0}}};
            r_rem   <= '0;
            r_quot  <= '0;
            r_phase <= PH_EST;
            r_limb  <= '0;
        end
        // divide by one second in ns a 32-bit limb at a time: estimate the limb
        // quotient through the reciprocal, form the remainder, then correct
        if (i_cmd.div) begin
            case (r_phase)
                PH_EST: begin
                    r_mq    <= est_in * RECIP_NS;
                    r_phase <= PH_SUB;
                end
                PH_SUB: begin
                    r_qe    <= qe;
                    r_diff  <= div_diff[DIFF_W-1:0];
                    r_phase <= PH_FIX;
                end
                PH_FIX: begin
                    r_rem   <= fix_rem[REM_W-1:0];
                    r_quot  <= {r_quot[DL_W-LIMB_W-1:0], r_qe + LIMB_W'(fix_k)};
                    r_prod  <= {r_prod[PROD_W-LIMB_W-1:0], {LIMB_W{1'b0}}};
                    r_limb  <= r_limb + 2'd1;
                    r_phase <= PH_EST;
                end
                default: begin
                    r_phase <= PH_EST;
                end
            endcase
        end
        if (i_cmd.add) begin
            r_x.dl <= r_now + r_quot + {{(DL_W-1){1'b0}}, (r_rem != '0)};
            r_x.h  <= r_handle;
        end
        if (i_cmd.cmp) begin
            if (r_count == '0 || r_x.dl < r_qa.dl) begin
                r_cmp_write <= 1'b1;
                r_cmp_value <= r_x.dl;
            end
            r_hole <= r_count[IDX_W-1:0];
        end
        if (i_cmd.up_rd) begin
            r_par <= parent;
            if (r_hole == '0) begin
                r_accepted <= 1'b1;
            end
        end
        if (i_cmd.up_cmp) begin
            if (up_move) begin
                r_hole <= r_par;
            end else begin
                r_accepted <= 1'b1;
            end
        end
        if (i_cmd.fire_ld) begin
            r_exp_valid  <= 1'b1;
            r_exp_handle <= r_qa.h;
            r_x          <= r_qb;
            r_hole       <= '0;
        end
        if (i_cmd.dn_rd) begin
            r_l <= l_idx;
            r_r <= l_idx + CHILD_W'(1);
        end
        if (i_cmd.dn_cmp && dn_move) begin
            r_hole <= child_idx;
        end
        if (i_cmd.fin) begin
            r_cmp_write <= 1'b1;
            r_cmp_value <= r_qa.dl;
        end
    end

    assign o_stat.is_fire   = (i_opcode == OP_FIRE);
    assign o_stat.full      = (r_count == CNT_W'(DEPTH));
    assign o_stat.empty     = (r_count == '0);
    assign o_stat.div_last  = (r_limb == LAST_LIMB) && (r_phase == PH_FIX);
    assign o_stat.up_top    = (r_hole == '0);
    assign o_stat.up_move   = up_move;
    assign o_stat.new_empty = (cnt_dec == '0);
    assign o_stat.dn_move   = dn_move;

    assign o_accepted       = r_accepted;
    assign o_expired_valid  = r_exp_valid;
    assign o_expired_handle = r_exp_handle;
    assign o_compare_write  = r_cmp_write;
    assign o_compare_value  = r_cmp_value;
    assign o_irq_unmasked   = r_irq;
    assign o_entry_count    = r_count;

endmodule
`default_nettype wire

// ===== hdl/timeout_deadline_queue.sv =====
`default_nettype none
// Channel   | Transfer when            | Signals
// ----------+--------------------------+-------------------------------------------
// command   | start && !busy           | i_opcode, i_now_count, i_delay_ns, i_handle
// result    | o_result_valid (1 cycle) | o_accepted .. o_entry_count
// config    | i_cfg_valid && o_cfg_ready | i_cfg_data (counter_freq_hz)
// Add: load, two partial multiplies, sum, divide by 1e9 over three 32-bit limbs (each
// estimate, subtract and fix), add, compare, then climb the heap. Fire: sift the last
// entry down from the root and read the new root for the compare write; the last entry
// out skips that; a reject or an empty fire goes straight to the result. Each heap level
// is a read and a compare step. The heap store has one write and two registered read
// ports. Synchronous active-low reset clears count and interrupt and sets the frequency
// to FREQ_RESET. Results appear for one cycle and are not held off.
module timeout_deadline_queue
    import tdq_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   start,
    output logic                        busy,
    input  wire logic                   i_cfg_valid,
    output logic                        o_cfg_ready,
    input  wire logic [FREQ_W-1:0]      i_cfg_data,
    input  wire logic                   i_opcode,
    input  wire logic [DL_W-1:0]        i_now_count,
    input  wire logic [DL_W-1:0]        i_delay_ns,
    input  wire logic [HANDLE_BITS-1:0] i_handle,
    output logic                        o_result_valid,
    output logic                        o_accepted,
    output logic                        o_expired_valid,
    output logic [HANDLE_BITS-1:0]      o_expired_handle,
    output logic                        o_compare_write,
    output logic [DL_W-1:0]             o_compare_value,
    output logic                        o_irq_unmasked,
    output logic [CNT_W-1:0]            o_entry_count
);

    t_cmd  cmd;
    t_stat stat;

    assign o_cfg_ready = !busy;

    tdq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (busy),
        .o_done  (o_result_valid)
    );

    tdq_dpath u_dpath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_stat           (stat),
        .i_cfg_we         (i_cfg_valid && o_cfg_ready),
        .i_cfg_data       (i_cfg_data),
        .i_opcode         (i_opcode),
        .i_now_count      (i_now_count),
        .i_delay_ns       (i_delay_ns),
        .i_handle         (i_handle),
        .o_accepted       (o_accepted),
        .o_expired_valid  (o_expired_valid),
        .o_expired_handle (o_expired_handle),
        .o_compare_write  (o_compare_write),
        .o_compare_value  (o_compare_value),
        .o_irq_unmasked   (o_irq_unmasked),
        .o_entry_count    (o_entry_count)
    );

endmodule
`default_nettype wire

// ===== hdl/tdq_checker.sv =====
`default_nettype none
module tdq_checker
    import tdq_pkg::*;
(
    input wire logic                   i_clk,
    input wire logic                   i_rst_n,
    input wire logic                   start,
    input wire logic                   busy,
    input wire logic                   o_result_valid,
    input wire logic                   o_accepted,
    input wire logic                   o_expired_valid,
    input wire logic                   o_compare_write,
    input wire logic                   o_irq_unmasked,
    input wire logic [CNT_W-1:0]       o_entry_count
);

    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |=> !o_result_valid)
        else $error("result strobe longer than one cycle");

    a_take_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("transfer taken without going busy");

    a_add_or_fire: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> !(o_accepted && o_expired_valid))
        else $error("result both stored and expired");

    a_add_unmasks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_accepted) |-> (o_irq_unmasked && o_entry_count != '0))
        else $error("stored add left interrupt masked or queue empty");

    a_last_masks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_expired_valid && !o_compare_write)
            |-> (!o_irq_unmasked && o_entry_count == '0))
        else $error("fire without compare write left entries or unmasked");

endmodule

bind timeout_deadline_queue tdq_checker u_tdq_checker (.*);
`default_nettype wire

// ===== test/tb_top.sv =====
`default_nettype none
module tb_top;
    import tdq_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   start;
    logic                   busy;
    logic                   i_cfg_valid;
    logic                   o_cfg_ready;
    logic [FREQ_W-1:0]      i_cfg_data;
    logic                   i_opcode;
    logic [DL_W-1:0]        i_now_count;
    logic [DL_W-1:0]        i_delay_ns;
    logic [HANDLE_BITS-1:0] i_handle;
    logic                   o_result_valid;
    logic                   o_accepted;
    logic                   o_expired_valid;
    logic [HANDLE_BITS-1:0] o_expired_handle;
    logic                   o_compare_write;
    logic [DL_W-1:0]        o_compare_value;
    logic                   o_irq_unmasked;
    logic [CNT_W-1:0]       o_entry_count;

    timeout_deadline_queue i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_data       (i_cfg_data),
        .i_opcode         (i_opcode),
        .i_now_count      (i_now_count),
        .i_delay_ns       (i_delay_ns),
        .i_handle         (i_handle),
        .o_result_valid   (o_result_valid),
        .o_accepted       (o_accepted),
        .o_expired_valid  (o_expired_valid),
        .o_expired_handle (o_expired_handle),
        .o_compare_write  (o_compare_write),
        .o_compare_value  (o_compare_value),
        .o_irq_unmasked   (o_irq_unmasked),
        .o_entry_count    (o_entry_count)
    );

    typedef struct packed {
        logic                   accepted;
        logic                   exp_valid;
        logic [HANDLE_BITS-1:0] exp_handle;
        logic                   cmp_write;
        logic [DL_W-1:0]        cmp_value;
        logic                   irq;
        logic [CNT_W-1:0]       count;
    } t_outcome;

    typedef struct {
        logic                   op;
        logic [DL_W-1:0]        now;
        logic [DL_W-1:0]        delay;
        logic [HANDLE_BITS-1:0] h;
        logic                   known;
        t_outcome               res;
    } t_row;

    // timer state mirror
    t_entry            heap_q [DEPTH];
    int unsigned       pending;
    logic              irq_on;
    logic [FREQ_W-1:0] freq_hz;

    t_outcome outcome_q [$];
    int       mismatches;
    t_row     rows [$];

    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    initial begin
        #50ms;
        $display("FAILED: results differ");
        $finish;
    end

    function automatic logic [DL_W-1:0] tick_count(logic [DL_W-1:0] ns, logic [FREQ_W-1:0] f);
        logic [PROD_W-1:0] prod;
        logic [PROD_W-1:0] quo;
        prod = PROD_W'(ns) * PROD_W'(f);
        quo  = prod / PROD_W'(1000000000);
        if (prod % PROD_W'(1000000000) != '0) begin
            quo = quo + PROD_W'(1);
        end
        return quo[DL_W-1:0];
    endfunction

    function automatic logic before_slot(int a, int b);
        if (heap_q[a].dl != heap_q[b].dl) begin
            return heap_q[a].dl < heap_q[b].dl;
        end
        return heap_q[a].h < heap_q[b].h;
    endfunction

    function automatic void swap_slots(int a, int b);
        t_entry t;
        t = heap_q[a];
        heap_q[a] = heap_q[b];
        heap_q[b] = t;
    endfunction

    function automatic t_outcome timer_step(logic op, logic [DL_W-1:0] now,
                                            logic [DL_W-1:0] delay,
                                            logic [HANDLE_BITS-1:0] h);
        t_outcome o;
        logic [DL_W-1:0] dl;
        int i, p, l, r, m, n;
        o = '0;
        if (op == OP_ADD) begin
            if (pending < DEPTH) begin
                dl = now + tick_count(delay, freq_hz);
                if (pending == 0 || dl < heap_q[0].dl) begin
                    o.cmp_write = 1'b1;
                    o.cmp_value = dl;
                end
                heap_q[pending] = '{dl: dl, h: h};
                i = pending;
                pending++;
                while (i > 0) begin
                    p = (i - 1) / 2;
                    if (!before_slot(i, p)) break;
                    swap_slots(i, p);
                    i = p;
                end
                irq_on = 1'b1;
                o.accepted = 1'b1;
            end
        end else if (pending > 0) begin
            n = pending - 1;
            o.exp_valid  = 1'b1;
            o.exp_handle = heap_q[0].h;
            heap_q[0] = heap_q[n];
            pending = n;
            i = 0;
            forever begin
                l = 2 * i + 1;
                r = l + 1;
                m = i;
                if (l < n && before_slot(l, m)) m = l;
                if (r < n && before_slot(r, m)) m = r;
                if (m == i) break;
                swap_slots(i, m);
                i = m;
            end
            if (n == 0) begin
                irq_on = 1'b0;
            end else begin
                o.cmp_write = 1'b1;
                o.cmp_value = heap_q[0].dl;
            end
        end
        o.irq   = irq_on;
        o.count = CNT_W'(pending);
        return o;
    endfunction

    task automatic report_mismatch(string what, logic [DL_W-1:0] got, logic [DL_W-1:0] want);
        $display("mismatch %s: got 0x%0h, want 0x%0h at %0t", what, got, want, $realtime);
        mismatches++;
    endtask

    always @(posedge i_clk) begin
        t_outcome w;
        if (i_rst_n && o_result_valid) begin
            if (outcome_q.size() == 0) begin
                report_mismatch("unexpected result", DL_W'(o_entry_count), '0);
            end else begin
                w = outcome_q.pop_front();
                if (o_accepted !== w.accepted)
                    report_mismatch("accepted", DL_W'(o_accepted), DL_W'(w.accepted));
                if (o_expired_valid !== w.exp_valid)
                    report_mismatch("expired_valid", DL_W'(o_expired_valid),
                                    DL_W'(w.exp_valid));
                if (o_expired_handle !== w.exp_handle)
                    report_mismatch("expired_handle", DL_W'(o_expired_handle),
                                    DL_W'(w.exp_handle));
                if (o_compare_write !== w.cmp_write)
                    report_mismatch("compare_write", DL_W'(o_compare_write),
                                    DL_W'(w.cmp_write));
                if (o_compare_value !== w.cmp_value)
                    report_mismatch("compare_value", o_compare_value, w.cmp_value);
                if (o_irq_unmasked !== w.irq)
                    report_mismatch("irq_unmasked", DL_W'(o_irq_unmasked), DL_W'(w.irq));
                if (o_entry_count !== w.count)
                    report_mismatch("entry_count", DL_W'(o_entry_count), DL_W'(w.count));
            end
        end
    end

    task automatic idle_gap();
        int n;
        if ($urandom_range(0, 2) == 0) begin
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(1, 3);
            repeat (n) @(negedge i_clk);
        end
    endtask

    // hold start until the transfer, then drop at the next falling edge
    task automatic issue(logic op, logic [DL_W-1:0] now, logic [DL_W-1:0] delay,
                         logic [HANDLE_BITS-1:0] h, logic known, t_outcome want);
        t_outcome p;
        i_opcode    = op;
        i_now_count = now;
        i_delay_ns  = delay;
        i_handle    = h;
        start       = 1'b1;
        do @(posedge i_clk); while (busy);
        p = timer_step(op, now, delay, h);
        if (known && p !== want) begin
            report_mismatch("table row", DL_W'(p), DL_W'(want));
        end
        outcome_q.push_back(p);
        @(negedge i_clk);
        start = 1'b0;
        idle_gap();
    endtask

    task automatic drain();
        int guard;
        guard = 0;
        while (outcome_q.size() != 0 && guard < 20000) begin
            @(negedge i_clk);
            guard++;
        end
        repeat (300) @(negedge i_clk);
    endtask

    task automatic set_freq(logic [FREQ_W-1:0] f);
        drain();
        i_cfg_data  = f;
        i_cfg_valid = 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        freq_hz = f;
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    function automatic logic [DL_W-1:0] rand64();
        logic [DL_W-1:0] v;
        v = {$urandom, $urandom};
        case ($urandom_range(0, 5))
            0: v = '0;
            1: v = '1;
            2: v = v >> $urandom_range(1, 63);
            default: ;
        endcase
        return v;
    endfunction

    function automatic t_outcome make_res(logic acc, logic ev, logic [HANDLE_BITS-1:0] eh,
                                          logic cw, logic [DL_W-1:0] cv, logic irq, int cnt);
        t_outcome o;
        o = '{accepted: acc, exp_valid: ev, exp_handle: eh, cmp_write: cw,
              cmp_value: cv, irq: irq, count: CNT_W'(cnt)};
        return o;
    endfunction

    initial begin
        int k, phase;
        logic op;
        mismatches  = 0;
        pending     = 0;
        irq_on      = 1'b0;
        freq_hz     = FREQ_RESET;
        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_data  = '0;
        i_opcode    = OP_ADD;
        i_now_count = '0;
        i_delay_ns  = '0;
        i_handle    = '0;
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;

        // fire on empty, zero delay add, 1 s add, tie handling, wrap, then drain
        rows.push_back('{OP_FIRE, 64'd0, 64'd0, 16'd0, 1'b1,
                         make_res(1'b0, 1'b0, 16'd0, 1'b0, 64'd0, 1'b0, 0)});
        rows.push_back('{OP_ADD, 64'd100, 64'd0, 16'hffff, 1'b1,
                         make_res(1'b1, 1'b0, 16'd0, 1'b1, 64'd100, 1'b1, 1)});
        rows.push_back('{OP_ADD, 64'd0, 64'd1000000000, 16'd5, 1'b1,
                         make_res(1'b1, 1'b0, 16'd0, 1'b0, 64'd0, 1'b1, 2)});
        rows.push_back('{OP_ADD, 64'd100, 64'd0, 16'd0, 1'b1,
                         make_res(1'b1, 1'b0, 16'd0, 1'b0, 64'd0, 1'b1, 3)});
        rows.push_back('{OP_ADD, 64'd99, 64'd1, 16'd7, 1'b1,
                         make_res(1'b1, 1'b0, 16'd0, 1'b0, 64'd0, 1'b1, 4)});
        rows.push_back('{OP_ADD, '1, '1, 16'h8000, 1'b0, '0});
        rows.push_back('{OP_ADD, 64'd0, 64'd0, 16'd1, 1'b1,
                         make_res(1'b1, 1'b0, 16'd0, 1'b1, 64'd0, 1'b1, 6)});
        rows.push_back('{OP_FIRE, 64'd0, 64'd0, 16'd0, 1'b1,
                         make_res(1'b0, 1'b1, 16'd1, 1'b1, 64'd100, 1'b1, 5)});
        rows.push_back('{OP_FIRE, '1, '1, '1, 1'b1,
                         make_res(1'b0, 1'b1, 16'd0, 1'b1, 64'd100, 1'b1, 4)});
        for (k = 0; k < 4; k++) rows.push_back('{OP_FIRE, '0, '0, '0, 1'b0, '0});
        rows.push_back('{OP_FIRE, '0, '0, '0, 1'b1,
                         make_res(1'b0, 1'b0, 16'd0, 1'b0, 64'd0, 1'b0, 0)});
        // fill past full
        for (k = 0; k < 17; k++) rows.push_back('{OP_ADD, rand64(), rand64(), 16'(k), 1'b0, '0});
        foreach (rows[j]) issue(rows[j].op, rows[j].now, rows[j].delay, rows[j].h,
                                rows[j].known, rows[j].res);

        for (phase = 0; phase < 5; phase++) begin
            case (phase)
                0: set_freq('0);
                1: set_freq('1);
                2: set_freq(32'd1);
                3: set_freq($urandom);
                default: set_freq(FREQ_RESET);
            endcase
            for (k = 0; k < 130; k++) begin
                // bias toward filling or emptying in runs so both full and empty recur
                if (pending == 0) op = ($urandom_range(0, 4) == 0) ? OP_FIRE : OP_ADD;
                else if (pending == DEPTH) op = ($urandom_range(0, 3) == 0) ? OP_ADD : OP_FIRE;
                else op = (((k / 20) % 2) == 0) ? ($urandom_range(0, 3) != 0 ? OP_ADD : OP_FIRE)
                                               : ($urandom_range(0, 3) != 0 ? OP_FIRE : OP_ADD);
                issue(op, rand64(), rand64(),
                      ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 3)) : 16'($urandom),
                      1'b0, '0);
            end
        end
        drain();

        if (mismatches == 0 && outcome_q.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end
endmodule
`default_nettype wire
